// ===== design/acss_pkg.sv =====
// acss_pkg: shared types and constants for the adc channel scan sequencer
// holds phase codes, action codes, register indexes and the result record
// no dependencies; used by adc_channel_scan_sequencer_unit and tb
`timescale 1ns / 1ps
`default_nettype none

package acss_pkg;

  // widths of the transaction fields
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned CODE_W   = 24;
  localparam int unsigned ACT_W    = 4;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned SETTLE_W = 8;
  localparam int unsigned STALL_W  = 9;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // default for the scan wrap limit
  localparam int unsigned MAX_CHANNELS_DEF = 16;

  // poll limits on the newer board
  localparam logic [STALL_W-1:0] STALL_LIMIT = 9'd255;
  localparam logic [STALL_W-1:0] STALL_SAT   = 9'd511;

  // input operations
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_PIN     = 2'd1;
  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_OPEN    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_OPENING = 4'd2;
  localparam logic [PHASE_W-1:0] PH_TRIG_I  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_READ_I  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_TRIG_V  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_READ_V  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CLOSE   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_NOWORK  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_TRIG_IV = 4'd9;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
  localparam logic [ACT_W-1:0] ACT_OPEN       = 4'd1;
  localparam logic [ACT_W-1:0] ACT_RESET_OPEN = 4'd2;
  localparam logic [ACT_W-1:0] ACT_CONVERT    = 4'd3;
  localparam logic [ACT_W-1:0] ACT_TRIG_I     = 4'd4;
  localparam logic [ACT_W-1:0] ACT_READ_I     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_TRIG_V     = 4'd6;
  localparam logic [ACT_W-1:0] ACT_READ_V     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_TRIG_BOTH  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_REINIT     = 4'd9;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_NEWER_BOARD   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_SETTLE_TICKS  = 2'd2;

  // one result transaction
  typedef struct packed {
    logic             new_sample;
    logic             store_voltage;
    logic             store_current;
    logic [CH_W-1:0]  sample_channel;
    logic [CH_W-1:0]  mux_channel;
    logic [ACT_W-1:0] action;
  } result_t;

endpackage

`default_nettype wire

// ===== design/adc_channel_scan_sequencer_unit.sv =====
// adc_channel_scan_sequencer_unit: one sequencer step per input transaction
// depends on acss_pkg for codes, widths and the result record
//
//  channel | group               | payload
//  in      | in_tvalid/in_tready  | tuser: op; tdata: pin_channel, ready flags, adc_code
//  out     | out_tvalid/out_tready| tdata: action, channels, store flags, new_sample
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
// each transaction is one step: the step is decided from the state registers
// in one pass and lands in the result register when the transaction is accepted
// a transaction is taken every cycle while the result register is empty or
// being drained; only a held result stops the input side
// reset (rst_n low at a clock edge) restores the state, configuration and valid registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module adc_channel_scan_sequencer_unit #(
  parameter int unsigned MAX_CHANNELS = acss_pkg::MAX_CHANNELS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // input stream
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // op [1:0]
  input  wire  [acss_pkg::OP_W-1:0]         in_tuser,
  // pin_channel [3:0], current_ready_n [4], voltage_ready_n [5], adc_code [29:6]
  input  wire  [acss_pkg::IN_DATA_W-1:0]    in_tdata,
  // result stream
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // action [3:0], mux_channel [7:4], sample_channel [11:8],
  // store_current [12], store_voltage [13], new_sample [14]
  output logic [acss_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration writes
  input  wire                               cfg_we,
  input  wire  [acss_pkg::IDX_W-1:0]        cfg_index,
  input  wire  [acss_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned LOG_CH = $clog2(MAX_CHANNELS);
  localparam int unsigned SCAN_W = (LOG_CH > acss_pkg::CH_W) ? LOG_CH : acss_pkg::CH_W;
  localparam int unsigned CMP_W  = SCAN_W + 1;

  // input fields
  logic [acss_pkg::OP_W-1:0]   op;
  logic [acss_pkg::CH_W-1:0]   pin_channel;
  logic                        current_ready_n;
  logic                        voltage_ready_n;
  logic [acss_pkg::CODE_W-1:0] adc_code;

  assign op              = in_tuser;
  assign pin_channel     = in_tdata[3:0];
  assign current_ready_n = in_tdata[4];
  assign voltage_ready_n = in_tdata[5];
  assign adc_code        = in_tdata[29:6];

  // configuration registers
  logic                           newer_board_r;
  logic [acss_pkg::COUNT_W-1:0]   channel_count_r;
  logic [acss_pkg::SETTLE_W-1:0]  settle_ticks_r;

  // sequencer state
  logic [acss_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [SCAN_W-1:0]              scan_channel_r, scan_channel_nxt;
  logic [acss_pkg::SETTLE_W-1:0]  settle_count_r, settle_count_nxt;
  logic                           pinned_mode_r, pinned_mode_nxt;
  logic                           pinned_switched_r, pinned_switched_nxt;
  logic [acss_pkg::CH_W-1:0]      pinned_channel_r, pinned_channel_nxt;
  logic [SCAN_W-1:0]              saved_channel_r, saved_channel_nxt;
  logic [acss_pkg::STALL_W-1:0]   stall_count_r, stall_count_nxt;
  logic                           mux_parked_r, mux_parked_nxt;

  // result register
  logic                           out_tvalid_r;
  acss_pkg::result_t              result_r, result_nxt;

  logic in_accept;

  // helper values for the step
  logic [acss_pkg::SETTLE_W-1:0]  settle_inc;
  logic                           settle_done;
  logic                           stall_hit;
  logic [acss_pkg::STALL_W-1:0]   stall_inc;
  logic [CMP_W-1:0]               next_ch;
  logic [SCAN_W-1:0]              advanced_ch;
  logic [SCAN_W-1:0]              pinned_ext;
  logic                           code_nonzero;

  assign in_tready = ~out_tvalid_r | out_tready;
  assign in_accept = in_tvalid & in_tready;

  // settle counter wraps at 8 bits
  assign settle_inc  = settle_count_r + acss_pkg::SETTLE_W'(1);
  assign settle_done = (settle_inc >= settle_ticks_r);

  // data-ready poll counter saturates
  assign stall_hit = (stall_count_r >= acss_pkg::STALL_LIMIT);
  assign stall_inc = (stall_count_r < acss_pkg::STALL_SAT) ?
                     stall_count_r + acss_pkg::STALL_W'(1) : stall_count_r;

  // round-robin wrap at the channel count or the channel limit
  assign next_ch     = {1'b0, scan_channel_r} + CMP_W'(1);
  assign advanced_ch = ((next_ch >= CMP_W'(channel_count_r)) ||
                        (next_ch >= CMP_W'(MAX_CHANNELS))) ?
                       '0 : next_ch[SCAN_W-1:0];
  assign pinned_ext   = SCAN_W'(pinned_channel_r);
  assign code_nonzero = (adc_code != '0);

  // one sequencer step
  always_comb begin
    phase_nxt           = phase_r;
    scan_channel_nxt    = scan_channel_r;
    settle_count_nxt    = settle_count_r;
    pinned_mode_nxt     = pinned_mode_r;
    pinned_switched_nxt = pinned_switched_r;
    pinned_channel_nxt  = pinned_channel_r;
    saved_channel_nxt   = saved_channel_r;
    stall_count_nxt     = stall_count_r;
    mux_parked_nxt      = mux_parked_r;
    result_nxt          = '0;

    case (op)
      acss_pkg::OP_PIN: begin
        saved_channel_nxt  = scan_channel_r;
        pinned_channel_nxt = pin_channel;
        pinned_mode_nxt    = 1'b1;
        mux_parked_nxt     = 1'b0;
      end
      acss_pkg::OP_TRIGGER: begin
        phase_nxt = acss_pkg::PH_TRIG_IV;
      end
      acss_pkg::OP_RELEASE: begin
        scan_channel_nxt    = saved_channel_r;
        pinned_mode_nxt     = 1'b0;
        phase_nxt           = acss_pkg::PH_IDLE;
        pinned_switched_nxt = 1'b0;
      end
      default: begin
        if (!newer_board_r) begin
          // older board: converters read in turn, no data-ready
          case (phase_r)
            acss_pkg::PH_IDLE: begin
              phase_nxt        = acss_pkg::PH_OPEN;
              settle_count_nxt = '0;
              scan_channel_nxt = '0;
            end
            acss_pkg::PH_OPEN: begin
              settle_count_nxt = '0;
              if (pinned_mode_r) begin
                scan_channel_nxt       = pinned_ext;
                result_nxt.action      = acss_pkg::ACT_RESET_OPEN;
                result_nxt.mux_channel = pinned_channel_r;
                phase_nxt              = acss_pkg::PH_NOWORK;
              end else begin
                result_nxt.action      = acss_pkg::ACT_OPEN;
                result_nxt.mux_channel = scan_channel_r[acss_pkg::CH_W-1:0];
                phase_nxt              = acss_pkg::PH_OPENING;
              end
            end
            acss_pkg::PH_OPENING: begin
              settle_count_nxt = settle_inc;
              if (settle_done) begin
                phase_nxt         = acss_pkg::PH_TRIG_I;
                result_nxt.action = acss_pkg::ACT_CONVERT;
                settle_count_nxt  = '0;
              end
            end
            acss_pkg::PH_TRIG_I: begin
              result_nxt.action = acss_pkg::ACT_TRIG_I;
              phase_nxt         = acss_pkg::PH_READ_I;
            end
            acss_pkg::PH_READ_I: begin
              result_nxt.action         = acss_pkg::ACT_READ_I;
              result_nxt.sample_channel = scan_channel_r[acss_pkg::CH_W-1:0];
              result_nxt.store_current  = 1'b1;
              phase_nxt                 = acss_pkg::PH_TRIG_V;
            end
            acss_pkg::PH_TRIG_V: begin
              result_nxt.action = acss_pkg::ACT_TRIG_V;
              phase_nxt         = acss_pkg::PH_READ_V;
            end
            acss_pkg::PH_READ_V: begin
              result_nxt.action         = acss_pkg::ACT_READ_V;
              result_nxt.sample_channel = scan_channel_r[acss_pkg::CH_W-1:0];
              result_nxt.store_voltage  = 1'b1;
              result_nxt.new_sample     = 1'b1;
              phase_nxt                 = acss_pkg::PH_CLOSE;
            end
            acss_pkg::PH_CLOSE: begin
              if (!pinned_mode_r) begin
                scan_channel_nxt = advanced_ch;
              end
              phase_nxt = acss_pkg::PH_OPEN;
            end
            acss_pkg::PH_NOWORK: begin
              phase_nxt = phase_r;
            end
            default: begin
              phase_nxt = acss_pkg::PH_IDLE;
            end
          endcase
        end else begin
          // newer board: both converters at once, data-ready polled
          case (phase_r)
            acss_pkg::PH_IDLE: begin
              phase_nxt        = acss_pkg::PH_OPEN;
              settle_count_nxt = '0;
              scan_channel_nxt = '0;
            end
            acss_pkg::PH_OPEN: begin
              settle_count_nxt  = '0;
              phase_nxt         = acss_pkg::PH_OPENING;
              result_nxt.action = acss_pkg::ACT_OPEN;
              if (pinned_mode_r) begin
                pinned_switched_nxt    = 1'b1;
                scan_channel_nxt       = pinned_ext;
                result_nxt.mux_channel = pinned_channel_r;
              end else begin
                result_nxt.mux_channel = scan_channel_r[acss_pkg::CH_W-1:0];
              end
            end
            acss_pkg::PH_OPENING: begin
              settle_count_nxt = settle_inc;
              if (settle_done) begin
                phase_nxt = (pinned_mode_r && pinned_switched_r) ?
                            acss_pkg::PH_NOWORK : acss_pkg::PH_TRIG_IV;
                settle_count_nxt = '0;
              end
            end
            acss_pkg::PH_TRIG_IV: begin
              result_nxt.action = acss_pkg::ACT_TRIG_BOTH;
              phase_nxt         = acss_pkg::PH_READ_I;
              stall_count_nxt   = '0;
            end
            acss_pkg::PH_READ_I, acss_pkg::PH_READ_V: begin
              if ((phase_r == acss_pkg::PH_READ_I) ? !current_ready_n
                                                   : !voltage_ready_n) begin
                result_nxt.sample_channel = scan_channel_r[acss_pkg::CH_W-1:0];
                if (phase_r == acss_pkg::PH_READ_I) begin
                  result_nxt.action        = acss_pkg::ACT_READ_I;
                  result_nxt.store_current = code_nonzero;
                  phase_nxt                = acss_pkg::PH_READ_V;
                end else begin
                  result_nxt.action        = acss_pkg::ACT_READ_V;
                  result_nxt.store_voltage = code_nonzero;
                  result_nxt.new_sample    = code_nonzero;
                  phase_nxt                = acss_pkg::PH_CLOSE;
                end
              end else begin
                stall_count_nxt = stall_inc;
                if (stall_hit) begin
                  // poll limit reached: soft reinit of the sequencer
                  result_nxt.action   = acss_pkg::ACT_REINIT;
                  phase_nxt           = acss_pkg::PH_IDLE;
                  scan_channel_nxt    = '0;
                  saved_channel_nxt   = '0;
                  pinned_mode_nxt     = 1'b0;
                  pinned_switched_nxt = 1'b0;
                end
              end
            end
            acss_pkg::PH_CLOSE: begin
              if (!pinned_mode_r) begin
                scan_channel_nxt = advanced_ch;
                phase_nxt        = acss_pkg::PH_OPEN;
              end else if (mux_parked_r) begin
                phase_nxt = acss_pkg::PH_NOWORK;
              end else begin
                scan_channel_nxt = pinned_ext;
                phase_nxt        = acss_pkg::PH_OPEN;
              end
            end
            acss_pkg::PH_NOWORK: begin
              mux_parked_nxt = 1'b1;
            end
            default: begin
              phase_nxt = acss_pkg::PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newer_board_r   <= 1'b1;
      channel_count_r <= acss_pkg::COUNT_W'(16);
      settle_ticks_r  <= acss_pkg::SETTLE_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        acss_pkg::REG_NEWER_BOARD:   newer_board_r   <= cfg_wdata[0];
        acss_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[acss_pkg::COUNT_W-1:0];
        acss_pkg::REG_SETTLE_TICKS:  settle_ticks_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= acss_pkg::PH_IDLE;
      scan_channel_r    <= '0;
      settle_count_r    <= '0;
      pinned_mode_r     <= 1'b0;
      pinned_switched_r <= 1'b0;
      pinned_channel_r  <= '0;
      saved_channel_r   <= '0;
      stall_count_r     <= '0;
      mux_parked_r      <= 1'b0;
    end else if (in_accept) begin
      phase_r           <= phase_nxt;
      scan_channel_r    <= scan_channel_nxt;
      settle_count_r    <= settle_count_nxt;
      pinned_mode_r     <= pinned_mode_nxt;
      pinned_switched_r <= pinned_switched_nxt;
      pinned_channel_r  <= pinned_channel_nxt;
      saved_channel_r   <= saved_channel_nxt;
      stall_count_r     <= stall_count_nxt;
      mux_parked_r      <= mux_parked_nxt;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = acss_pkg::OUT_DATA_W'(result_r);

  // a reinit leaves the sequencer idle and unpinned
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && result_nxt.action == acss_pkg::ACT_REINIT) |=>
      (phase_r == acss_pkg::PH_IDLE && !pinned_mode_r && scan_channel_r == '0))
    else $error("reinit did not return the sequencer to idle");

  // a stored voltage code always completes a sample
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && result_r.store_voltage) |-> result_r.new_sample)
    else $error("voltage stored without new sample");

  // the mux channel is only driven with an open action
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && result_r.action != acss_pkg::ACT_OPEN &&
     result_r.action != acss_pkg::ACT_RESET_OPEN) |-> (result_r.mux_channel == '0))
    else $error("mux channel set without an open action");

  // triggering both converters restarts the poll counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && result_nxt.action == acss_pkg::ACT_TRIG_BOTH) |=>
      (stall_count_r == '0 && phase_r == acss_pkg::PH_READ_I))
    else $error("poll counter not cleared after trigger");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for adc_channel_scan_sequencer_unit
// holds a scan sequencer predictor, stream drivers and a result checker
// depends on acss_pkg and the sequencer unit only
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_COUNT   = 13;
  localparam int PHASE_ITEMS   = 50;
  localparam int STALL_PHASE   = 5;
  localparam int STALL_POLLS   = 258;
  localparam int LONG_HOLD     = 120;

  // one row of the directed table
  typedef struct packed {
    logic [acss_pkg::OP_W-1:0]   op;
    logic [acss_pkg::CH_W-1:0]   pin;
    logic                        rdy_i_n;
    logic                        rdy_v_n;
    logic [acss_pkg::CODE_W-1:0] code;
    logic                        typed;
    logic [acss_pkg::ACT_W-1:0]  exp_action;
    logic [acss_pkg::CH_W-1:0]   exp_mux;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [acss_pkg::OP_W-1:0]       in_tuser = '0;
  logic [acss_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [acss_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [acss_pkg::IDX_W-1:0]      cfg_index = '0;
  logic [acss_pkg::CFG_W-1:0]      cfg_wdata = '0;

  // predictor copy of the registers
  logic                          cfg_newer = 1'b1;
  logic [acss_pkg::COUNT_W-1:0]  cfg_count = 5'd16;
  logic [acss_pkg::SETTLE_W-1:0] cfg_settle = 8'd8;

  // predictor copy of the sequencer state
  logic [acss_pkg::PHASE_W-1:0]  seq_phase = acss_pkg::PH_IDLE;
  logic [acss_pkg::CH_W-1:0]     seq_channel = '0;
  logic [acss_pkg::SETTLE_W-1:0] seq_settle = '0;
  logic                          seq_pinned = 1'b0;
  logic                          seq_switched = 1'b0;
  logic [acss_pkg::CH_W-1:0]     seq_pin_channel = '0;
  logic [acss_pkg::CH_W-1:0]     seq_saved_channel = '0;
  logic [acss_pkg::STALL_W-1:0]  seq_stall = '0;
  logic                          seq_parked = 1'b0;

  acss_pkg::result_t pending_results [$];
  stim_row_t         directed_rows [$];
  int                error_count = 0;
  int                cycle_count = 0;
  bit                sender_no_gap = 1'b0;

  adc_channel_scan_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // back to the idle phase after a stalled poll limit
  task automatic soft_restart();
    seq_phase = acss_pkg::PH_IDLE;
    seq_channel = '0;
    seq_saved_channel = '0;
    seq_pinned = 1'b0;
    seq_switched = 1'b0;
  endtask

  // round-robin step, wrapping at the channel count or the mux size
  task automatic next_channel();
    int nxt;
    nxt = int'(seq_channel) + 1;
    if (nxt >= int'(cfg_count) || nxt >= acss_pkg::MAX_CHANNELS_DEF) nxt = 0;
    seq_channel = acss_pkg::CH_W'(nxt);
  endtask

  // counts a failed data-ready poll, returns 1 once the limit is reached
  function automatic bit poll_stalled();
    bit hit;
    hit = (seq_stall >= acss_pkg::STALL_LIMIT);
    if (seq_stall < acss_pkg::STALL_SAT) seq_stall = seq_stall + 1'b1;
    return hit;
  endfunction

  // one sequencer step for one input transaction
  task automatic sequence_step(input logic [acss_pkg::OP_W-1:0] op,
                               input logic [acss_pkg::CH_W-1:0] pin,
                               input logic rdy_i_n, input logic rdy_v_n,
                               input logic [acss_pkg::CODE_W-1:0] code,
                               output acss_pkg::result_t res);
    res = '0;
    if (op == acss_pkg::OP_PIN) begin
      seq_saved_channel = seq_channel;
      seq_pin_channel = pin;
      seq_pinned = 1'b1;
      seq_parked = 1'b0;
    end else if (op == acss_pkg::OP_TRIGGER) begin
      seq_phase = acss_pkg::PH_TRIG_IV;
    end else if (op == acss_pkg::OP_RELEASE) begin
      seq_channel = seq_saved_channel;
      seq_pinned = 1'b0;
      seq_phase = acss_pkg::PH_IDLE;
      seq_switched = 1'b0;
    end else if (!cfg_newer) begin
      // older board: converters read in turn, no data-ready
      case (seq_phase)
        acss_pkg::PH_IDLE: begin
          seq_phase = acss_pkg::PH_OPEN;
          seq_settle = '0;
          seq_channel = '0;
        end
        acss_pkg::PH_OPEN: begin
          seq_settle = '0;
          if (seq_pinned) begin
            seq_channel = seq_pin_channel;
            res.action = acss_pkg::ACT_RESET_OPEN;
            res.mux_channel = seq_channel;
            seq_phase = acss_pkg::PH_NOWORK;
          end else begin
            res.action = acss_pkg::ACT_OPEN;
            res.mux_channel = seq_channel;
            seq_phase = acss_pkg::PH_OPENING;
          end
        end
        acss_pkg::PH_OPENING: begin
          seq_settle = seq_settle + 1'b1;
          if (seq_settle >= cfg_settle) begin
            seq_phase = acss_pkg::PH_TRIG_I;
            res.action = acss_pkg::ACT_CONVERT;
            seq_settle = '0;
          end
        end
        acss_pkg::PH_TRIG_I: begin
          res.action = acss_pkg::ACT_TRIG_I;
          seq_phase = acss_pkg::PH_READ_I;
        end
        acss_pkg::PH_READ_I: begin
          res.action = acss_pkg::ACT_READ_I;
          res.sample_channel = seq_channel;
          res.store_current = 1'b1;
          seq_phase = acss_pkg::PH_TRIG_V;
        end
        acss_pkg::PH_TRIG_V: begin
          res.action = acss_pkg::ACT_TRIG_V;
          seq_phase = acss_pkg::PH_READ_V;
        end
        acss_pkg::PH_READ_V: begin
          res.action = acss_pkg::ACT_READ_V;
          res.sample_channel = seq_channel;
          res.store_voltage = 1'b1;
          res.new_sample = 1'b1;
          seq_phase = acss_pkg::PH_CLOSE;
        end
        acss_pkg::PH_CLOSE: begin
          if (!seq_pinned) next_channel();
          seq_phase = acss_pkg::PH_OPEN;
        end
        acss_pkg::PH_NOWORK: begin
        end
        default: seq_phase = acss_pkg::PH_IDLE;
      endcase
    end else begin
      // newer board: both converters at once, data-ready polled
      case (seq_phase)
        acss_pkg::PH_IDLE: begin
          seq_phase = acss_pkg::PH_OPEN;
          seq_settle = '0;
          seq_channel = '0;
        end
        acss_pkg::PH_OPEN: begin
          seq_settle = '0;
          seq_phase = acss_pkg::PH_OPENING;
          if (seq_pinned) begin
            seq_switched = 1'b1;
            seq_channel = seq_pin_channel;
          end
          res.action = acss_pkg::ACT_OPEN;
          res.mux_channel = seq_channel;
        end
        acss_pkg::PH_OPENING: begin
          seq_settle = seq_settle + 1'b1;
          if (seq_settle >= cfg_settle) begin
            seq_phase = (seq_pinned && seq_switched) ? acss_pkg::PH_NOWORK
                                                     : acss_pkg::PH_TRIG_IV;
            seq_settle = '0;
          end
        end
        acss_pkg::PH_TRIG_IV: begin
          res.action = acss_pkg::ACT_TRIG_BOTH;
          seq_phase = acss_pkg::PH_READ_I;
          seq_stall = '0;
        end
        acss_pkg::PH_READ_I: begin
          if (!rdy_i_n) begin
            res.action = acss_pkg::ACT_READ_I;
            res.sample_channel = seq_channel;
            res.store_current = (code != '0);
            seq_phase = acss_pkg::PH_READ_V;
          end else if (poll_stalled()) begin
            res.action = acss_pkg::ACT_REINIT;
            soft_restart();
          end
        end
        acss_pkg::PH_READ_V: begin
          if (!rdy_v_n) begin
            res.action = acss_pkg::ACT_READ_V;
            res.sample_channel = seq_channel;
            res.store_voltage = (code != '0);
            res.new_sample = (code != '0);
            seq_phase = acss_pkg::PH_CLOSE;
          end else if (poll_stalled()) begin
            res.action = acss_pkg::ACT_REINIT;
            soft_restart();
          end
        end
        acss_pkg::PH_CLOSE: begin
          if (!seq_pinned) begin
            next_channel();
            seq_phase = acss_pkg::PH_OPEN;
          end else if (seq_parked) begin
            seq_phase = acss_pkg::PH_NOWORK;
          end else begin
            seq_channel = seq_pin_channel;
            seq_phase = acss_pkg::PH_OPEN;
          end
        end
        acss_pkg::PH_NOWORK: seq_parked = 1'b1;
        default: seq_phase = acss_pkg::PH_IDLE;
      endcase
    end
  endtask

  // offer one transaction, after a random gap unless sender_no_gap is set; called and left at a falling edge
  task automatic send_item(input logic [acss_pkg::OP_W-1:0] op,
                           input logic [acss_pkg::CH_W-1:0] pin,
                           input logic rdy_i_n, input logic rdy_v_n,
                           input logic [acss_pkg::CODE_W-1:0] code,
                           input logic typed, input acss_pkg::result_t typed_res);
    int                gap;
    acss_pkg::result_t predicted;
    gap = sender_no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser <= op;
    in_tdata <= {2'b00, code, rdy_v_n, rdy_i_n, pin};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sequence_step(op, pin, rdy_i_n, rdy_v_n, code, predicted);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // random transaction; a stall burst gives ticks with both converters busy
  task automatic send_random_item(input bit stall_burst);
    logic [acss_pkg::OP_W-1:0]   op;
    logic [acss_pkg::CODE_W-1:0] code;
    logic                        rdy_i_n;
    logic                        rdy_v_n;
    int                          pick;
    pick = $urandom_range(0, 99);
    if (stall_burst || pick < 88) op = acss_pkg::OP_TICK;
    else if (pick < 92) op = acss_pkg::OP_PIN;
    else if (pick < 96) op = acss_pkg::OP_TRIGGER;
    else op = acss_pkg::OP_RELEASE;
    rdy_i_n = stall_burst ? 1'b1 : ($urandom_range(0, 3) == 0);
    rdy_v_n = stall_burst ? 1'b1 : ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 15))
      0, 1: code = '0;
      2: code = '1;
      default: code = acss_pkg::CODE_W'($urandom);
    endcase
    send_item(op, acss_pkg::CH_W'($urandom), rdy_i_n, rdy_v_n, code, 1'b0, '0);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // one register write; leaves the write enable high
  task automatic put_reg(input logic [acss_pkg::IDX_W-1:0] idx,
                         input logic [acss_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      acss_pkg::REG_NEWER_BOARD:   cfg_newer = value[0];
      acss_pkg::REG_CHANNEL_COUNT: cfg_count = value[acss_pkg::COUNT_W-1:0];
      acss_pkg::REG_SETTLE_TICKS:  cfg_settle = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic newer,
                                input logic [acss_pkg::COUNT_W-1:0] count,
                                input logic [acss_pkg::SETTLE_W-1:0] settle);
    put_reg(acss_pkg::REG_NEWER_BOARD, {7'd0, newer});
    put_reg(acss_pkg::REG_CHANNEL_COUNT, {3'd0, count});
    put_reg(acss_pkg::REG_SETTLE_TICKS, settle);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input logic [acss_pkg::OP_W-1:0] op,
                         input logic [acss_pkg::CH_W-1:0] pin,
                         input logic rdy_i_n, input logic rdy_v_n,
                         input logic [acss_pkg::CODE_W-1:0] code, input logic typed,
                         input logic [acss_pkg::ACT_W-1:0] exp_action,
                         input logic [acss_pkg::CH_W-1:0] exp_mux);
    directed_rows.push_back({op, pin, rdy_i_n, rdy_v_n, code, typed, exp_action, exp_mux});
  endtask

  // stimulus
  initial begin
    stim_row_t                     row;
    acss_pkg::result_t             typed_res;
    logic                          newer;
    logic [acss_pkg::COUNT_W-1:0]  count;
    logic [acss_pkg::SETTLE_W-1:0] settle;

    // directed table on the reset settings: newer board, 16 channels, 8 ticks settle
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b1, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b1, acss_pkg::ACT_OPEN, 4'h0);
    add_row(acss_pkg::OP_TRIGGER, 4'hF, 1'b0, 1'b0, 24'hFFFFFF, 1'b1, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b1,
            acss_pkg::ACT_TRIG_BOTH, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b0, 1'b1, 24'hFFFFFF, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b0, 1'b1, 24'h123456, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    // zero voltage code: no store, no new sample
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b0, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_PIN, 4'hF, 1'b1, 1'b1, 24'h000000, 1'b1, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TRIGGER, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b1, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    // zero current code is not stored
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b0, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b0, 24'hFFFFFF, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    // pinned close, then the mux opens on the pinned channel
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_PIN, 4'h0, 1'b1, 1'b1, 24'hFFFFFF, 1'b1, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_RELEASE, 4'hF, 1'b0, 1'b0, 24'hFFFFFF, 1'b1, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b0, acss_pkg::ACT_NONE, 4'h0);
    add_row(acss_pkg::OP_RELEASE, 4'h0, 1'b1, 1'b1, 24'h000000, 1'b1, acss_pkg::ACT_NONE, 4'h0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      typed_res = '0;
      typed_res.action = row.exp_action;
      typed_res.mux_channel = row.exp_mux;
      send_item(row.op, row.pin, row.rdy_i_n, row.rdy_v_n, row.code, row.typed, typed_res);
    end

    // random phases, settings changed only with nothing in flight
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: apply_settings(1'b0, 5'd3, 8'd1);
          2: apply_settings(1'b0, 5'd0, 8'd0);
          3: apply_settings(1'b1, 5'd31, 8'd2);
          4: apply_settings(1'b1, 5'd1, 8'd255);
          STALL_PHASE: apply_settings(1'b1, 5'd2, 8'd1);
          6: apply_settings(1'b0, 5'd17, 8'd255);
          7: apply_settings(1'b1, 5'd16, 8'd0);
          default: begin
            newer = 1'($urandom);
            count = acss_pkg::COUNT_W'($urandom);
            settle = ($urandom_range(0, 3) == 0) ? acss_pkg::SETTLE_W'($urandom)
                                                 : acss_pkg::SETTLE_W'($urandom_range(0, 4));
            apply_settings(newer, count, settle);
          end
        endcase
      end
      sender_no_gap = ($urandom_range(0, 3) == 0);
      if (ph == STALL_PHASE) begin
        // poll limit hit while waiting for the current converter
        send_item(acss_pkg::OP_TRIGGER, 4'h0, 1'b1, 1'b1, 24'h0, 1'b0, '0);
        send_item(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h0, 1'b0, '0);
        repeat (STALL_POLLS) send_random_item(1'b1);
        // and again while waiting for the voltage converter
        send_item(acss_pkg::OP_TRIGGER, 4'h0, 1'b1, 1'b1, 24'h0, 1'b0, '0);
        send_item(acss_pkg::OP_TICK, 4'h0, 1'b1, 1'b1, 24'h0, 1'b0, '0);
        send_item(acss_pkg::OP_TICK, 4'h0, 1'b0, 1'b1, 24'hABCDEF, 1'b0, '0);
        repeat (STALL_POLLS) send_random_item(1'b1);
      end
      repeat (PHASE_ITEMS) send_random_item(1'b0);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // result side: random stalls, quiet stretches and a long hold-off now and then
  initial begin
    int gap;
    int taken;
    bit no_stall;
    taken = 0;
    no_stall = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (taken % 40 == 0) no_stall = ($urandom_range(0, 2) == 0);
      if (taken % 500 == 200) gap = LONG_HOLD;
      else gap = no_stall ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    acss_pkg::result_t got;
    acss_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = acss_pkg::result_t'(out_tdata[$bits(acss_pkg::result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("action", want.action, got.action);
        check_field("mux_channel", want.mux_channel, got.mux_channel);
        check_field("sample_channel", want.sample_channel, got.sample_channel);
        check_field("store_current", want.store_current, got.store_current);
        check_field("store_voltage", want.store_voltage, got.store_voltage);
        check_field("new_sample", want.new_sample, got.new_sample);
      end
    end
  end

endmodule

// ===== adc_channel_scan_sequencer_unit.f =====
design/acss_pkg.sv
design/adc_channel_scan_sequencer_unit.sv
tb/tb.sv
